// ===== rtl/assert_macros.svh =====
// Assertion helpers for the ring buffer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SBR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SBR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sbr_pkg.sv =====
package sbr_pkg;

  localparam int DEPTH = 4096;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;

  localparam logic [7:0] CR_BYTE = 8'h0D;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  data_byte;
    logic [12:0] line_number;
    logic [11:0] read_offset;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  removed_byte;
    logic [11:0] line_start;
    logic [11:0] line_length;
    logic        is_last_line;
    logic [7:0]  stored_byte;
  } rsp_t;

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] prev_pos(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
  endfunction

endpackage

// ===== rtl/sbr_text_ram.sv =====
module sbr_text_ram (
  input  logic                  clk,
  input  logic                  we,
  input  logic [sbr_pkg::AW-1:0] addr,
  input  logic [7:0]            wdata,
  output logic [7:0]            rdata
);

  logic [7:0] mem [sbr_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/sbr_lap_mod.sv =====
// Lap reduction: n > k gives ((n - 1) mod k) + 1, else n; k == 0 gives 0.
// Restoring remainder, one dividend bit per cycle.
module sbr_lap_mod (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [13:0]           n,
  input  logic [sbr_pkg::CW-1:0] k,
  output logic                  done,
  output logic [13:0]           result
);

  logic        active;
  logic [3:0]  cnt;
  logic [13:0] dividend;
  logic [13:0] rem;
  logic [13:0] divisor;
  logic [13:0] rem_sh;
  logic [13:0] rem_next;

  always_comb begin
    rem_sh   = {rem[12:0], dividend[13]};
    rem_next = (rem_sh >= divisor) ? rem_sh - divisor : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        divisor <= 14'(k);
        if (k == '0) begin
          result <= '0;
          done   <= 1'b1;
        end else if (n <= 14'(k)) begin
          result <= n;
          done   <= 1'b1;
        end else begin
          dividend <= n - 14'd1;
          rem      <= '0;
          cnt      <= '0;
          active   <= 1'b1;
        end
      end else if (active) begin
        rem      <= rem_next;
        dividend <= {dividend[12:0], 1'b0};
        cnt      <= cnt + 4'd1;
        if (cnt == 4'd13) begin
          active <= 1'b0;
          done   <= 1'b1;
          result <= rem_next + 14'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/scrollback_line_ring_buffer_core.sv =====
// Channel   Direction  Payload             Handshake
// cmd       in         sbr_pkg::cmd_t      cmd_valid / cmd_stall
// rsp       out        sbr_pkg::rsp_t      rsp_valid / rsp_stall
//
// One command at a time; the text sits in a single-port RAM with a registered read.
// Add steps through S_ADD0..S_ADD2, remove through S_REM0, read through S_RD0;
// S_DONE then loads the result register. Find selects an anchor, reduces laps
// in sbr_lap_mod, then walks to the line and along its characters byte by byte,
// one RAM read each. After reset a clearing pass writes CR to all 4096 entries;
// cmd_stall is high meanwhile. A stalled result holds; the next command may
// start while it waits and finishes once the result register is free.
`include "assert_macros.svh"

module scrollback_line_ring_buffer_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  sbr_pkg::cmd_t cmd_item,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sbr_pkg::rsp_t rsp_item
);

  localparam int AW = sbr_pkg::AW;
  localparam int CW = sbr_pkg::CW;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_ADD0    = 4'd2;
  localparam logic [3:0] S_ADD1    = 4'd3;
  localparam logic [3:0] S_ADD2    = 4'd4;
  localparam logic [3:0] S_REM0    = 4'd5;
  localparam logic [3:0] S_RD0     = 4'd6;
  localparam logic [3:0] S_MOD     = 4'd7;
  localparam logic [3:0] S_FWD_RD  = 4'd8;
  localparam logic [3:0] S_FWD_CHK = 4'd9;
  localparam logic [3:0] S_BWD_RD  = 4'd10;
  localparam logic [3:0] S_BWD_CHK = 4'd11;
  localparam logic [3:0] S_LEN_RD  = 4'd12;
  localparam logic [3:0] S_LEN_CHK = 4'd13;
  localparam logic [3:0] S_DONE    = 4'd14;

  logic [3:0]    state;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] oldest;
  logic [AW-1:0] wi;
  logic [AW-1:0] view_index;
  logic [CW-1:0] char_count;
  logic [CW-1:0] cr_total;
  logic [12:0]   line_total;
  logic [12:0]   view_line;
  logic [AW-1:0] ptr;
  logic [13:0]   n;
  logic [CW-1:0] len;
  logic          fwd;
  logic          old0_cr;
  logic          old1_cr;
  sbr_pkg::cmd_t item;
  sbr_pkg::rsp_t res;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic          mod_start;
  logic          mod_done;
  logic [13:0]   mod_result;

  // find anchor selection, signed as in the line arithmetic
  logic signed [14:0] line_s, lines_s, vline_s, diff_s, half_s, thr_s, number_s;
  logic [AW-1:0]      anchor;
  logic               fwd_sel;
  logic [13:0]        nraw;
  logic               is_last;

  // add bookkeeping
  logic          add_full;
  logic          add_is_cr;
  logic [12:0]   lt_next;

  always_comb begin
    line_s  = 15'(cmd_item.line_number);
    lines_s = 15'(line_total);
    vline_s = 15'(view_line);
    diff_s  = lines_s - vline_s;
    // division by two truncating toward zero
    half_s  = diff_s[14] ? ((diff_s + 15'sd1) >>> 1) : (diff_s >>> 1);
    thr_s   = vline_s + half_s;
    if (line_s > vline_s) begin
      if (line_s > thr_s) begin
        anchor   = sbr_pkg::next_pos(wi);
        number_s = lines_s;
      end else begin
        anchor   = view_index;
        number_s = vline_s;
      end
    end else if (line_s > (vline_s >>> 1)) begin
      anchor   = view_index;
      number_s = vline_s;
    end else begin
      anchor   = oldest;
      number_s = '0;
    end
    fwd_sel = (line_s >= number_s);
    nraw    = fwd_sel ? 14'(line_s - number_s) : 14'(number_s - line_s + 15'sd1);
    is_last = (line_s >= lines_s - 15'sd1);
  end

  always_comb begin
    add_full  = (sbr_pkg::next_pos(wi) == oldest);
    add_is_cr = (item.data_byte == sbr_pkg::CR_BYTE);
    lt_next   = line_total + 13'(add_is_cr) - 13'(add_full && old1_cr);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = ptr;
    ram_wdata = sbr_pkg::CR_BYTE;
    case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      S_IDLE: begin
        case (cmd_item.cmd)
          sbr_pkg::CMD_ADD:    ram_addr = wi;
          sbr_pkg::CMD_REMOVE: ram_addr = sbr_pkg::prev_pos(wi);
          default:             ram_addr = AW'(cmd_item.read_offset);
        endcase
      end
      S_ADD0: ram_addr = sbr_pkg::next_pos(wi);
      S_ADD1: begin
        ram_we    = 1'b1;
        ram_addr  = wi;
        ram_wdata = item.data_byte;
      end
      S_ADD2: begin
        ram_we   = 1'b1;
        ram_addr = sbr_pkg::next_pos(wi);
      end
      S_REM0:   ram_we   = (ram_rdata != sbr_pkg::CR_BYTE);
      S_BWD_RD: ram_addr = sbr_pkg::prev_pos(ptr);
      default:  ram_addr = ptr;
    endcase
  end

  assign mod_start = (state == S_IDLE) && cmd_valid && (cmd_item.cmd == sbr_pkg::CMD_FIND)
                     && (char_count != '0);
  assign cmd_stall = (state != S_IDLE);

  sbr_text_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  sbr_lap_mod u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (mod_start),
    .n      (nraw),
    .k      (cr_total),
    .done   (mod_done),
    .result (mod_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      oldest     <= '0;
      wi         <= '0;
      view_index <= '0;
      char_count <= '0;
      cr_total   <= CW'(sbr_pkg::DEPTH);
      line_total <= '0;
      view_line  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(sbr_pkg::DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            item <= cmd_item;
            case (cmd_item.cmd)
              sbr_pkg::CMD_ADD: begin
                res   <= '0;
                state <= S_ADD0;
              end
              sbr_pkg::CMD_REMOVE: begin
                res   <= '0;
                ptr   <= sbr_pkg::prev_pos(wi);
                state <= (char_count == '0) ? S_DONE : S_REM0;
              end
              sbr_pkg::CMD_FIND: begin
                if (char_count == '0) begin
                  res   <= '{is_last_line: 1'b1, default: '0};
                  state <= S_DONE;
                end else begin
                  res       <= '{is_last_line: is_last, default: '0};
                  ptr       <= anchor;
                  fwd       <= fwd_sel;
                  view_line <= cmd_item.line_number + 13'd1;
                  state     <= S_MOD;
                end
              end
              default: begin
                res   <= '0;
                state <= S_RD0;
              end
            endcase
          end
        end
        S_ADD0: begin
          old0_cr <= (ram_rdata == sbr_pkg::CR_BYTE);
          state   <= S_ADD1;
        end
        S_ADD1: begin
          old1_cr <= (ram_rdata == sbr_pkg::CR_BYTE);
          state   <= S_ADD2;
        end
        S_ADD2: begin
          wi         <= sbr_pkg::next_pos(wi);
          line_total <= lt_next;
          view_line  <= lt_next;
          view_index <= sbr_pkg::next_pos(sbr_pkg::next_pos(wi));
          if (add_full) begin
            oldest <= sbr_pkg::next_pos(oldest);
          end else begin
            char_count <= char_count + 1'b1;
          end
          cr_total <= cr_total + CW'(1) + CW'(add_is_cr) - CW'(old0_cr) - CW'(old1_cr);
          state    <= S_DONE;
        end
        S_REM0: begin
          if (ram_rdata != sbr_pkg::CR_BYTE) begin
            res.removed_byte <= ram_rdata;
            wi               <= ptr;
            char_count       <= char_count - 1'b1;
            cr_total         <= cr_total + 1'b1;
          end
          state <= S_DONE;
        end
        S_RD0: begin
          res.stored_byte <= ram_rdata;
          state           <= S_DONE;
        end
        S_MOD: begin
          if (mod_done) begin
            n     <= mod_result;
            state <= fwd ? S_FWD_RD : S_BWD_RD;
          end
        end
        S_FWD_RD: begin
          if (n == '0) begin
            res.line_start <= 12'(ptr);
            len            <= '0;
            state          <= S_LEN_RD;
          end else begin
            state <= S_FWD_CHK;
          end
        end
        S_FWD_CHK: begin
          if (ram_rdata == sbr_pkg::CR_BYTE) begin
            n <= n - 14'd1;
          end
          ptr   <= sbr_pkg::next_pos(ptr);
          state <= S_FWD_RD;
        end
        S_BWD_RD: begin
          if (n == '0) begin
            ptr            <= sbr_pkg::next_pos(ptr);
            res.line_start <= 12'(sbr_pkg::next_pos(ptr));
            len            <= '0;
            state          <= S_LEN_RD;
          end else begin
            ptr   <= sbr_pkg::prev_pos(ptr);
            state <= S_BWD_CHK;
          end
        end
        S_BWD_CHK: begin
          if (ram_rdata == sbr_pkg::CR_BYTE) begin
            n <= n - 14'd1;
          end
          state <= S_BWD_RD;
        end
        S_LEN_RD: state <= S_LEN_CHK;
        S_LEN_CHK: begin
          if (ram_rdata != sbr_pkg::CR_BYTE && len != CW'(sbr_pkg::DEPTH)) begin
            ptr   <= sbr_pkg::next_pos(ptr);
            len   <= len + 1'b1;
            state <= S_LEN_RD;
          end else begin
            view_index      <= sbr_pkg::next_pos(ptr);
            res.line_length <= 12'(len);
            state           <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_item  <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SBR_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, char_count < CW'(sbr_pkg::DEPTH),
    "character count reached ring depth")
  `SBR_ASSERT_IMP(a_lines_vs_crs, clk, rst, state == S_IDLE, 14'(line_total) < 14'(cr_total),
    "line count not below stored CR count")
  `SBR_ASSERT_IMP(a_rsp_from_done, clk, rst, $rose(rsp_valid), $past(state) == S_DONE,
    "result raised outside completion")
  `SBR_ASSERT_NXT(a_remove_moves_wi, clk, rst,
    state == S_REM0 && ram_rdata != sbr_pkg::CR_BYTE, wi == $past(ptr),
    "remove did not step write index back")

endmodule

// ===== tb/sv/scrollback_line_ring_buffer_core_tb.sv =====
`timescale 1ns / 100ps

module scrollback_line_ring_buffer_core_tb;
  import sbr_pkg::*;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  cmd_valid = 1'b0;
  logic  cmd_stall;
  cmd_t  cmd_item = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp_item;

  scrollback_line_ring_buffer_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the scrollback
  logic [7:0]  shadow_text [DEPTH];
  int          sh_oldest, sh_write, sh_chars, sh_lines, sh_vidx, sh_vline;
  rsp_t        pending_rsp [$];
  int          err_count = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          hold_left = 0;
  bit          hold_start = 1'b0;

  function automatic int wrap_next(int p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  function automatic int wrap_prev(int p);
    return (p == 0) ? DEPTH - 1 : p - 1;
  endfunction

  function automatic int drop_laps(int n, int k);
    if (k == 0) return 0;
    if (n > k) n -= k * ((n - 1) / k);
    return n;
  endfunction

  function automatic rsp_t scroll_predict(cmd_t c);
    rsp_t r;
    int   pos, line, num, k, n, len, off;
    r = '0;
    case (c.cmd)
      CMD_ADD: begin
        pos = sh_write;
        shadow_text[pos] = c.data_byte;
        pos = wrap_next(pos);
        sh_write = pos;
        if (c.data_byte == CR_BYTE) sh_lines++;
        if (pos == sh_oldest) begin
          if (shadow_text[sh_oldest] == CR_BYTE) sh_lines--;
          sh_oldest = wrap_next(sh_oldest);
        end else begin
          sh_chars++;
        end
        shadow_text[pos] = CR_BYTE;
        sh_vidx = wrap_next(pos);
        sh_vline = sh_lines;
      end
      CMD_REMOVE: begin
        if (sh_chars != 0) begin
          pos = wrap_prev(sh_write);
          if (shadow_text[pos] != CR_BYTE) begin
            r.removed_byte = shadow_text[pos];
            shadow_text[pos] = CR_BYTE;
            sh_write = pos;
            sh_chars--;
          end
        end
      end
      CMD_FIND: begin
        line = int'(c.line_number);
        if (sh_chars == 0) begin
          r.is_last_line = 1'b1;
        end else begin
          r.is_last_line = (line >= sh_lines - 1);
          if (line > sh_vline) begin
            if (line > sh_vline + (sh_lines - sh_vline) / 2) begin
              off = wrap_next(sh_write);
              num = sh_lines;
            end else begin
              off = sh_vidx;
              num = sh_vline;
            end
          end else if (line > sh_vline / 2) begin
            off = sh_vidx;
            num = sh_vline;
          end else begin
            off = sh_oldest;
            num = 0;
          end
          sh_vline = (line + 1) & 32'h1FFF;
          k = 0;
          for (int i = 0; i < DEPTH; i++) if (shadow_text[i] == CR_BYTE) k++;
          if (line >= num) begin
            n = drop_laps(line - num, k);
            while (n != 0) begin
              if (shadow_text[off] == CR_BYTE) n--;
              off = wrap_next(off);
            end
          end else begin
            n = drop_laps(num - line + 1, k);
            while (n != 0) begin
              off = wrap_prev(off);
              if (shadow_text[off] == CR_BYTE) n--;
            end
            off = wrap_next(off);
          end
          r.line_start = off[11:0];
          len = 0;
          while (shadow_text[off] != CR_BYTE && len < DEPTH) begin
            off = wrap_next(off);
            len++;
          end
          sh_vidx = wrap_next(off);
          r.line_length = len[11:0];
        end
      end
      default: r.stored_byte = shadow_text[c.read_offset];
    endcase
    return r;
  endfunction

  task automatic send_cmd(cmd_t c);
    cmd_valid <= 1'b1;
    cmd_item  <= c;
    do @(posedge clk); while (cmd_stall);
    pending_rsp.push_back(scroll_predict(c));
    if ($urandom_range(99) < send_idle) begin
      cmd_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  function automatic cmd_t make_cmd(logic [1:0] op, logic [7:0] b, logic [12:0] ln,
                                    logic [11:0] ro);
    cmd_t c;
    c.cmd = op;
    c.data_byte = b;
    c.line_number = ln;
    c.read_offset = ro;
    return c;
  endfunction

  // mostly text with line breaks, some edits, lookups near the stored lines
  function automatic cmd_t random_cmd();
    int   sel;
    cmd_t c;
    sel = int'($urandom_range(99));
    c.data_byte = 8'($urandom);
    c.line_number = 13'($urandom);
    c.read_offset = 12'($urandom);
    if (sel < 50) begin
      c.cmd = CMD_ADD;
      if ($urandom_range(5) == 0) c.data_byte = CR_BYTE;
      else if ($urandom_range(3) != 0) c.data_byte = 8'($urandom_range(8'h7E, 8'h20));
    end else if (sel < 65) begin
      c.cmd = CMD_REMOVE;
    end else if (sel < 85) begin
      c.cmd = CMD_FIND;
      if ($urandom_range(7) != 0) c.line_number = 13'($urandom_range(sh_lines + 2));
    end else begin
      c.cmd = CMD_READ;
      if ($urandom_range(1)) c.read_offset = 12'(sh_write - int'($urandom_range(8)));
    end
    return c;
  endfunction

  always @(posedge clk) begin
    if (hold_start) begin
      hold_left = 400;
      hold_start = 1'b0;
    end
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result %h", $time, rsp_item);
        err_count++;
      end else begin
        rsp_t e;
        e = pending_rsp.pop_front();
        if (e.removed_byte !== rsp_item.removed_byte) begin
          $display("%0t: removed_byte exp %h got %h", $time, e.removed_byte,
                   rsp_item.removed_byte);
          err_count++;
        end
        if (e.line_start !== rsp_item.line_start) begin
          $display("%0t: line_start exp %h got %h", $time, e.line_start,
                   rsp_item.line_start);
          err_count++;
        end
        if (e.line_length !== rsp_item.line_length) begin
          $display("%0t: line_length exp %h got %h", $time, e.line_length,
                   rsp_item.line_length);
          err_count++;
        end
        if (e.is_last_line !== rsp_item.is_last_line) begin
          $display("%0t: is_last_line exp %b got %b", $time, e.is_last_line,
                   rsp_item.is_last_line);
          err_count++;
        end
        if (e.stored_byte !== rsp_item.stored_byte) begin
          $display("%0t: stored_byte exp %h got %h", $time, e.stored_byte,
                   rsp_item.stored_byte);
          err_count++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic test_directed();
    send_cmd(make_cmd(CMD_REMOVE, 8'h00, 13'd0, 12'd0));
    send_cmd(make_cmd(CMD_FIND, 8'h00, 13'd0, 12'd0));
    send_cmd(make_cmd(CMD_FIND, 8'h00, 13'h1FFF, 12'd0));
    send_cmd(make_cmd(CMD_READ, 8'h00, 13'd0, 12'd0));
    send_cmd(make_cmd(CMD_READ, 8'h00, 13'd0, 12'hFFF));
    send_cmd(make_cmd(CMD_ADD, 8'h00, 13'd0, 12'd0));
    send_cmd(make_cmd(CMD_ADD, 8'hFF, 13'h1FFF, 12'hFFF));
    send_cmd(make_cmd(CMD_ADD, CR_BYTE, 13'd0, 12'd0));
    send_cmd(make_cmd(CMD_ADD, 8'h41, 13'd0, 12'd0));
    send_cmd(make_cmd(CMD_REMOVE, 8'h00, 13'd0, 12'd0));
    // newest byte is now a CR: remove must refuse
    send_cmd(make_cmd(CMD_REMOVE, 8'h00, 13'd0, 12'd0));
    send_cmd(make_cmd(CMD_ADD, 8'h42, 13'd0, 12'd0));
    send_cmd(make_cmd(CMD_FIND, 8'h00, 13'd0, 12'd0));
    send_cmd(make_cmd(CMD_FIND, 8'h00, 13'd1, 12'd0));
    send_cmd(make_cmd(CMD_FIND, 8'h00, 13'd4096, 12'd0));
    send_cmd(make_cmd(CMD_FIND, 8'h00, 13'h1FFF, 12'd0));
    send_cmd(make_cmd(CMD_FIND, 8'h00, 13'd0, 12'd0));
    send_cmd(make_cmd(CMD_READ, 8'h00, 13'd0, 12'd1));
    send_cmd(make_cmd(CMD_READ, 8'h00, 13'd0, 12'd3));
    send_cmd(make_cmd(CMD_READ, 8'h00, 13'h1FFF, 12'hFFF));
  endtask

  task automatic test_random(int count, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (count) send_cmd(random_cmd());
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    hold_start = 1'b1;
    repeat (40) send_cmd(random_cmd());
  endtask

  // add-heavy stretch with periodic lookups, edits and reads
  task automatic test_long_text();
    cmd_t c;
    send_idle = 10;
    recv_idle = 10;
    for (int i = 0; i < 316; i++) begin
      c = random_cmd();
      if (i % 60 == 59) c.cmd = CMD_FIND;
      else if (i % 97 == 50) c.cmd = CMD_REMOVE;
      else if (i % 53 == 20) c.cmd = CMD_READ;
      else begin
        c.cmd = CMD_ADD;
        if ($urandom_range(7) == 0) c.data_byte = CR_BYTE;
        else if (c.data_byte == CR_BYTE) c.data_byte = 8'h2E;
      end
      send_cmd(c);
    end
    send_cmd(make_cmd(CMD_FIND, 8'h00, 13'd0, 12'd0));
    send_cmd(make_cmd(CMD_FIND, 8'h00, 13'h1FFF, 12'd0));
    send_cmd(make_cmd(CMD_READ, 8'h00, 13'd0, 12'hFFF));
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) shadow_text[i] = CR_BYTE;
    sh_oldest = 0; sh_write = 0; sh_chars = 0;
    sh_lines = 0; sh_vidx = 0; sh_vline = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(240, 36, 63);
    test_random(240, 63, 36);
    test_random(240, 0, 0);
    test_backpressure();
    test_long_text();
    cmd_valid <= 1'b0;
    recv_idle = 0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0) $display("scrollback_line_ring_buffer_core_tb: clean");
    else $display("scrollback_line_ring_buffer_core_tb: errors");
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("scrollback_line_ring_buffer_core_tb: errors");
    $finish;
  end

endmodule
